@@ rtl/core/h3se_pkg.sv @@
// Package for the HTTP/3 response status extractor.
// Holds phase codes, the static status table and the result item type.
// No dependencies.
package h3se_pkg;

   localparam int FifoDepth = 4;

   typedef enum logic [2:0] {
      FR_TYPE  = 3'd0,
      FR_TYPEC = 3'd1,
      FR_LEN   = 3'd2,
      FR_LENC  = 3'd3,
      FR_HLEN  = 3'd4,
      FR_HLENC = 3'd5,
      FR_SKIP  = 3'd6,
      FR_HBODY = 3'd7
   } frame_phase_type;

   typedef enum logic [3:0] {
      FP_RIC       = 4'd0,
      FP_RIC_C     = 4'd1,
      FP_DB        = 4'd2,
      FP_DB_C      = 4'd3,
      FP_LINE      = 4'd4,
      FP_LINE_C    = 4'd5,
      FP_VLEN      = 4'd6,
      FP_VLEN_C    = 4'd7,
      FP_NAME_SKIP = 4'd8,
      FP_VAL_SKIP  = 4'd9,
      FP_VAL_KEEP  = 4'd10,
      FP_DONE_OK   = 4'd11,
      FP_DONE_FAIL = 4'd12
   } field_phase_type;

   localparam logic [1:0] KindIdx   = 2'd0;
   localparam logic [1:0] KindNref  = 2'd1;
   localparam logic [1:0] KindLname = 2'd2;

   typedef struct packed {
      logic [15:0] status_code;
      logic        failed;
   } result_type;

   typedef struct packed {
      logic        hit;
      logic [15:0] code;
   } status_hit_type;

   function automatic status_hit_type table_status(input logic [63:0] idx);
      status_hit_type r;
      r.hit = 1'b1;
      r.code = 16'd0;
      unique case (idx)
         64'd24: r.code = 16'd103;
         64'd25: r.code = 16'd200;
         64'd26: r.code = 16'd304;
         64'd27: r.code = 16'd404;
         64'd28: r.code = 16'd503;
         64'd63: r.code = 16'd100;
         64'd64: r.code = 16'd204;
         64'd65: r.code = 16'd206;
         64'd66: r.code = 16'd302;
         64'd67: r.code = 16'd400;
         64'd68: r.code = 16'd403;
         64'd69: r.code = 16'd421;
         64'd70: r.code = 16'd425;
         64'd71: r.code = 16'd500;
         default: r.hit = 1'b0;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/core/http3_response_status_extractor_top.sv @@
// HTTP/3 response status extractor, top level.
// Depends on h3se_pkg, h3se_front and h3se_fifo.
//
// Usage: stream bytes go in on req_data_byte with req_last_byte marking the
// final byte of a buffer; an item is taken when push is high and full is low.
// Frame headers are parsed and the first HEADERS frame is decoded as a QPACK
// field section. Each buffer yields one result item: rsp_status_code with
// rsp_failed low, or rsp_failed high and a zero status.
// Throughput is one byte per cycle while full is low; the front part updates
// its state once per byte. A result is written into a four-entry queue at the
// edge that takes its causing byte and shows on the result ports once it heads
// the queue. full rises only while the queue holds four waiting items, so a
// stalled receiver stops input only after that many buffers are pending.
// Reset is synchronous and active high; it empties the queue and returns the
// parser to the start of a buffer.
module http3_response_status_extractor_top #(
   parameter int FifoDepth = h3se_pkg::FifoDepth
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [7:0]         req_data_byte,
   input  logic               req_last_byte,
   output logic               empty,
   input  logic               pop,
   output logic signed [15:0] rsp_status_code,
   output logic               rsp_failed
);

   logic                 res_valid;
   h3se_pkg::result_type res_data;
   h3se_pkg::result_type q_data;

   h3se_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push && !full),
      .in_byte   (req_data_byte),
      .in_last   (req_last_byte),
      .res_valid (res_valid),
      .res_data  (res_data)
   );

   h3se_fifo #(.Depth(FifoDepth)) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (res_valid),
      .wr_data (res_data),
      .full    (full),
      .empty   (empty),
      .rd_en   (pop),
      .rd_data (q_data)
   );

   assign rsp_status_code = q_data.status_code;
   assign rsp_failed = q_data.failed;

endmodule

@@ rtl/core/h3se_front.sv @@
// Front part: frame header parsing and QPACK field line decoding.
// Depends on h3se_pkg; produces at most one result item per buffer.
module h3se_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [7:0]              in_byte,
   input  logic                    in_last,
   output logic                    res_valid,
   output h3se_pkg::result_type    res_data
);

   h3se_pkg::frame_phase_type frame_ff, frame_in;
   logic [61:0] vacc_ff, vacc_in;
   logic [2:0]  vleft_ff, vleft_in;
   logic [61:0] fleft_ff, fleft_in;
   h3se_pkg::field_phase_type field_ff, field_in;
   logic [63:0] pacc_ff, pacc_in;
   logic [5:0]  shift_ff, shift_in;
   logic [2:0]  flags_ff, flags_in;
   logic [63:0] skip_ff, skip_in;
   logic [23:0] digits_ff, digits_in;
   logic [15:0] pend_ff, pend_in;
   logic        answered_ff, answered_in;

   logic [61:0] rem;
   logic [61:0] vnew;
   logic [63:0] v;
   logic [63:0] addend;
   logic        done_int;
   logic [3:0]  bits;
   logic [7:0]  maxv;
   logic [2:0]  which;
   logic        emit;
   logic        emit_ok;
   logic [15:0] huff_val;
   logic        huff_ok;
   logic [15:0] ascii_val;
   logic [15:0] newpend;
   logic [23:0] dnew;
   h3se_pkg::status_hit_type th;
   logic        is_name;

   always_comb begin
      frame_in = frame_ff;
      vacc_in = vacc_ff;
      vleft_in = vleft_ff;
      fleft_in = fleft_ff;
      field_in = field_ff;
      pacc_in = pacc_ff;
      shift_in = shift_ff;
      flags_in = flags_ff;
      skip_in = skip_ff;
      digits_in = digits_ff;
      pend_in = pend_ff;
      answered_in = answered_ff;
      emit = 1'b0;
      emit_ok = 1'b0;
      rem = fleft_ff - 62'd1;
      vnew = 62'd0;
      v = 64'd0;
      addend = 64'd0;
      done_int = 1'b0;
      bits = 4'd7;
      maxv = 8'h7f;
      which = 3'd0;
      huff_val = 16'd0;
      huff_ok = 1'b0;
      ascii_val = 16'd0;
      newpend = pend_ff;
      dnew = 24'd0;
      th = h3se_pkg::table_status(64'd0);
      is_name = 1'b0;
      if (in_valid && !answered_ff) begin
         if (frame_ff != h3se_pkg::FR_SKIP && frame_ff != h3se_pkg::FR_HBODY) begin
            if (!frame_ff[0]) begin
               vnew = {56'd0, in_byte[5:0]};
               vleft_in = 3'((4'd1 << in_byte[7:6]) - 4'd1);
               done_int = (vleft_in == 3'd0);
               if (!done_int) begin
                  frame_in = h3se_pkg::frame_phase_type'({frame_ff[2:1], 1'b1});
               end
            end else begin
               vnew = {vacc_ff[53:0], in_byte};
               vleft_in = vleft_ff - 3'd1;
               done_int = (vleft_in == 3'd0);
            end
            vacc_in = vnew;
            if (done_int) begin
               priority case (frame_ff[2:1])
                  2'd0: frame_in = (vnew == 62'd1) ? h3se_pkg::FR_HLEN : h3se_pkg::FR_LEN;
                  2'd1: begin
                     if (vnew == 62'd0) begin
                        frame_in = h3se_pkg::FR_TYPE;
                     end else begin
                        fleft_in = vnew;
                        frame_in = h3se_pkg::FR_SKIP;
                     end
                  end
                  default: begin
                     field_in = h3se_pkg::FP_RIC;
                     pacc_in = 64'd0;
                     shift_in = 6'd0;
                     flags_in = 3'd0;
                     skip_in = 64'd0;
                     digits_in = 24'd0;
                     pend_in = 16'd0;
                     if (vnew == 62'd0) begin
                        emit = 1'b1;
                        frame_in = h3se_pkg::FR_HLEN;
                     end else begin
                        fleft_in = vnew;
                        frame_in = h3se_pkg::FR_HBODY;
                     end
                  end
               endcase
            end
         end else if (frame_ff == h3se_pkg::FR_SKIP) begin
            fleft_in = rem;
            if (rem == 62'd0) begin
               frame_in = h3se_pkg::FR_TYPE;
            end
         end else begin
            fleft_in = rem;
            which = {1'b0, field_ff[2:1]};
            done_int = 1'b0;
            if (field_ff < h3se_pkg::FP_NAME_SKIP) begin
               if (!field_ff[0]) begin
                  bits = 4'd7;
                  if (field_ff == h3se_pkg::FP_RIC) begin
                     bits = 4'd8;
                  end else if (field_ff == h3se_pkg::FP_LINE) begin
                     priority if (in_byte[7]) begin
                        bits = 4'd6;
                        flags_in = {h3se_pkg::KindIdx, in_byte[6]};
                     end else if (in_byte[6]) begin
                        bits = 4'd4;
                        flags_in = {h3se_pkg::KindNref, in_byte[4]};
                     end else if (in_byte[5]) begin
                        bits = 4'd3;
                        flags_in = {h3se_pkg::KindLname, 1'b0};
                     end else if (in_byte[4]) begin
                        bits = 4'd4;
                        flags_in = {h3se_pkg::KindIdx, 1'b0};
                     end else begin
                        bits = 4'd3;
                        flags_in = {h3se_pkg::KindNref, 1'b0};
                     end
                  end else if (field_ff == h3se_pkg::FP_VLEN) begin
                     flags_in = {1'b0, in_byte[7], flags_ff[0]};
                  end
                  maxv = 8'((9'd1 << bits) - 9'd1);
                  v = {56'd0, in_byte & maxv};
                  shift_in = 6'd0;
                  done_int = ((in_byte & maxv) != maxv);
                  if (!done_int) begin
                     field_in = h3se_pkg::field_phase_type'({field_ff[3:1], 1'b1});
                  end
               end else begin
                  addend = {57'd0, in_byte[6:0]} << shift_ff;
                  v = pacc_ff + addend;
                  if (!in_byte[7]) begin
                     done_int = 1'b1;
                  end else begin
                     shift_in = shift_ff + 6'd7;
                     if (shift_in > 6'd56) begin
                        field_in = h3se_pkg::FP_DONE_FAIL;
                     end
                  end
               end
               pacc_in = v;
               if (done_int) begin
                  th = h3se_pkg::table_status(v);
                  is_name = th.hit;
                  unique case (which)
                     3'd0: field_in = h3se_pkg::FP_DB;
                     3'd1: field_in = h3se_pkg::FP_LINE;
                     3'd2: begin
                        priority case (flags_in[2:1])
                           h3se_pkg::KindIdx: begin
                              if (flags_in[0] && th.hit) begin
                                 pend_in = th.code;
                                 field_in = h3se_pkg::FP_DONE_OK;
                              end else begin
                                 field_in = h3se_pkg::FP_LINE;
                              end
                           end
                           h3se_pkg::KindNref: begin
                              flags_in = {2'd0, flags_in[0] && is_name};
                              field_in = h3se_pkg::FP_VLEN;
                           end
                           default: begin
                              flags_in = 3'd0;
                              if (v > {2'd0, rem}) begin
                                 field_in = h3se_pkg::FP_DONE_FAIL;
                              end else if (v == 64'd0) begin
                                 field_in = h3se_pkg::FP_VLEN;
                              end else begin
                                 skip_in = v;
                                 field_in = h3se_pkg::FP_NAME_SKIP;
                              end
                           end
                        endcase
                     end
                     default: begin
                        if (v > {2'd0, rem}) begin
                           field_in = h3se_pkg::FP_DONE_FAIL;
                        end else if (flags_in[0] &&
                                     (flags_in[1] ? v == 64'd2 : v == 64'd3)) begin
                           skip_in = v;
                           digits_in = 24'd0;
                           field_in = h3se_pkg::FP_VAL_KEEP;
                        end else if (v == 64'd0) begin
                           field_in = h3se_pkg::FP_LINE;
                        end else begin
                           skip_in = v;
                           field_in = h3se_pkg::FP_VAL_SKIP;
                        end
                     end
                  endcase
               end
            end else begin
               skip_in = skip_ff - 64'd1;
               priority case (field_ff)
                  h3se_pkg::FP_NAME_SKIP: begin
                     if (skip_in == 64'd0) field_in = h3se_pkg::FP_VLEN;
                  end
                  h3se_pkg::FP_VAL_SKIP: begin
                     if (skip_in == 64'd0) field_in = h3se_pkg::FP_LINE;
                  end
                  h3se_pkg::FP_VAL_KEEP: begin
                     dnew = {digits_ff[15:0], in_byte};
                     digits_in = dnew;
                     huff_ok = (dnew[15:11] <= 5'd9) && (dnew[10:6] <= 5'd9)
                               && (dnew[5:1] <= 5'd9);
                     huff_val = {11'd0, dnew[15:11]} * 16'd100
                                + {11'd0, dnew[10:6]} * 16'd10
                                + {11'd0, dnew[5:1]};
                     ascii_val = 16'({8'd0, dnew[23:16]} * 16'd100)
                                 + 16'({8'd0, dnew[15:8]} * 16'd10)
                                 + {8'd0, dnew[7:0]} - 16'd5328;
                     if (skip_in == 64'd0) begin
                        if (flags_ff[1]) begin
                           if (huff_ok) begin
                              pend_in = huff_val;
                              field_in = h3se_pkg::FP_DONE_OK;
                           end else begin
                              field_in = h3se_pkg::FP_LINE;
                           end
                        end else begin
                           pend_in = ascii_val;
                           field_in = h3se_pkg::FP_DONE_OK;
                        end
                     end
                  end
                  default: skip_in = skip_ff;
               endcase
            end
            if (rem == 62'd0) begin
               emit = 1'b1;
               emit_ok = (field_in == h3se_pkg::FP_DONE_OK);
            end
         end
         newpend = pend_in;
         if (emit) answered_in = 1'b1;
      end
      if (in_valid && in_last && !answered_ff && !emit) begin
         emit = 1'b1;
         emit_ok = 1'b0;
      end
      if (in_valid && in_last) begin
         frame_in = h3se_pkg::FR_TYPE;
         vacc_in = 62'd0;
         vleft_in = 3'd0;
         fleft_in = 62'd0;
         answered_in = 1'b0;
         field_in = h3se_pkg::FP_RIC;
         pacc_in = 64'd0;
         shift_in = 6'd0;
         flags_in = 3'd0;
         skip_in = 64'd0;
         digits_in = 24'd0;
         pend_in = 16'd0;
      end
   end

   assign res_valid = emit;
   assign res_data.status_code = emit_ok ? newpend : 16'd0;
   assign res_data.failed = !emit_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= h3se_pkg::FR_TYPE;
         vacc_ff <= 62'd0;
         vleft_ff <= 3'd0;
         fleft_ff <= 62'd0;
         field_ff <= h3se_pkg::FP_RIC;
         pacc_ff <= 64'd0;
         shift_ff <= 6'd0;
         flags_ff <= 3'd0;
         skip_ff <= 64'd0;
         digits_ff <= 24'd0;
         pend_ff <= 16'd0;
         answered_ff <= 1'b0;
      end else begin
         frame_ff <= frame_in;
         vacc_ff <= vacc_in;
         vleft_ff <= vleft_in;
         fleft_ff <= fleft_in;
         field_ff <= field_in;
         pacc_ff <= pacc_in;
         shift_ff <= shift_in;
         flags_ff <= flags_in;
         skip_ff <= skip_in;
         digits_ff <= digits_in;
         pend_ff <= pend_in;
         answered_ff <= answered_in;
      end
   end

   ap_answer_once: assert property (@(posedge clock) disable iff (reset)
      (answered_ff && !(in_valid && in_last)) |-> !res_valid)
      else $error("result after answer");
   ap_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res_data.failed) |-> (res_data.status_code == 16'd0))
      else $error("failed result carries status");
   ap_last_clears: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_last) |=> (!answered_ff && frame_ff == h3se_pkg::FR_TYPE))
      else $error("state not cleared after last item");

endmodule

@@ rtl/core/h3se_fifo.sv @@
// Result queue between the front part and the result port.
// Depends on h3se_pkg for the result item type.
module h3se_fifo #(
   parameter int Depth = h3se_pkg::FifoDepth
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  h3se_pkg::result_type wr_data,
   output logic                 full,
   output logic                 empty,
   input  logic                 rd_en,
   output h3se_pkg::result_type rd_data
);

   localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1;

   h3se_pkg::result_type mem_ff [Depth];
   logic [Aw-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [Aw:0]   cnt_ff, cnt_in;
   logic          do_wr, do_rd;

   assign do_wr = wr_en && !full;
   assign do_rd = rd_en && !empty;
   assign full = (cnt_ff == (Aw+1)'(Depth));
   assign empty = (cnt_ff == '0);
   assign rd_data = mem_ff[rp_ff];

   always_comb begin
      wp_in = wp_ff;
      rp_in = rp_ff;
      if (do_wr) wp_in = (wp_ff == Aw'(Depth - 1)) ? '0 : wp_ff + 1'b1;
      if (do_rd) rp_in = (rp_ff == Aw'(Depth - 1)) ? '0 : rp_ff + 1'b1;
      cnt_in = cnt_ff + (Aw+1)'(do_wr) - (Aw+1)'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (do_wr) mem_ff[wp_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   ap_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (Aw+1)'(Depth))
      else $error("queue count beyond depth");
   ap_count: assert property (@(posedge clock) disable iff (reset)
      (do_wr && !do_rd) |=> (cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("queue count not advanced");
   ap_drain: assert property (@(posedge clock) disable iff (reset)
      (do_rd && !do_wr) |=> (cnt_ff == $past(cnt_ff) - 1'b1))
      else $error("queue count not reduced");

endmodule

@@ test/http3_response_status_extractor_top_test.sv @@
// Testbench for the HTTP/3 response status extractor top level.
// Drives byte items with random gaps and checks every result item against a
// local predictor of the frame and field-section parsing. Depends on h3se_pkg.
`timescale 1ns / 1ps

module http3_response_status_extractor_top_test;

   typedef struct {
      logic [7:0]  data;
      logic        last;
      logic        chk;
      logic [15:0] st;
      logic        fl;
   } byte_item_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              push = 1'b0;
   logic              full;
   logic [7:0]        req_data_byte = 8'd0;
   logic              req_last_byte = 1'b0;
   logic              empty;
   logic              pop = 1'b0;
   logic signed [15:0] rsp_status_code;
   logic              rsp_failed;

   byte_item_type          stim_q[$];
   h3se_pkg::result_type   status_q[$];
   logic [7:0]             bq[$];
   int            in_wait = 0;
   int            out_wait = 0;
   int            errors = 0;
   bit            calm = 0;

   h3se_pkg::frame_phase_type fr_ph;
   h3se_pkg::field_phase_type fp;
   logic [63:0]     vacc, fleft, pacc, skl;
   int              vleft, shc;
   logic [2:0]      flags;
   logic [23:0]     dig;
   logic [15:0]     pend;
   bit              answered;

   http3_response_status_extractor_top DUT (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_data_byte(req_data_byte), .req_last_byte(req_last_byte),
      .empty(empty), .pop(pop), .rsp_status_code(rsp_status_code),
      .rsp_failed(rsp_failed)
   );

   always #1 clock = ~clock;

   function automatic logic [15:0] index_status_code(input logic [63:0] idx);
      case (idx)
         64'd24: return 16'd103;
         64'd25: return 16'd200;
         64'd26: return 16'd304;
         64'd27: return 16'd404;
         64'd28: return 16'd503;
         64'd63: return 16'd100;
         64'd64: return 16'd204;
         64'd65: return 16'd206;
         64'd66: return 16'd302;
         64'd67: return 16'd400;
         64'd68: return 16'd403;
         64'd69: return 16'd421;
         64'd70: return 16'd425;
         64'd71: return 16'd500;
         default: return 16'd0;
      endcase
   endfunction

   function automatic int gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic clear_section();
      fp = h3se_pkg::FP_RIC;
      pacc = 0;
      shc = 0;
      flags = 0;
      skl = 0;
      dig = 0;
      pend = 0;
   endtask

   task automatic clear_all();
      fr_ph = h3se_pkg::FR_TYPE;
      vacc = 0;
      vleft = 0;
      fleft = 0;
      answered = 0;
      clear_section();
   endtask

   task automatic finish_int(input logic [1:0] which, input logic [63:0] rem);
      logic [15:0] code;
      code = index_status_code(pacc);
      if (which == 2'd0) begin
         fp = h3se_pkg::FP_DB;
      end else if (which == 2'd1) begin
         fp = h3se_pkg::FP_LINE;
      end else if (which == 2'd2) begin
         if (flags[2:1] == h3se_pkg::KindIdx) begin
            if (flags[0] && code != 0) begin
               pend = code;
               fp = h3se_pkg::FP_DONE_OK;
            end else begin
               fp = h3se_pkg::FP_LINE;
            end
         end else if (flags[2:1] == h3se_pkg::KindNref) begin
            flags = (flags[0] && code != 0) ? 3'd1 : 3'd0;
            fp = h3se_pkg::FP_VLEN;
         end else begin
            flags = 0;
            if (pacc > rem) fp = h3se_pkg::FP_DONE_FAIL;
            else if (pacc == 0) fp = h3se_pkg::FP_VLEN;
            else begin
               skl = pacc;
               fp = h3se_pkg::FP_NAME_SKIP;
            end
         end
      end else begin
         if (pacc > rem) fp = h3se_pkg::FP_DONE_FAIL;
         else if (flags[0] && (flags[1] ? pacc == 2 : pacc == 3)) begin
            skl = pacc;
            dig = 0;
            fp = h3se_pkg::FP_VAL_KEEP;
         end else if (pacc == 0) fp = h3se_pkg::FP_LINE;
         else begin
            skl = pacc;
            fp = h3se_pkg::FP_VAL_SKIP;
         end
      end
   endtask

   task automatic finish_value();
      logic [4:0] code;
      int val, d0, d1, d2;
      bit bad;
      val = 0;
      bad = 0;
      if (flags[1]) begin
         for (int i = 0; i < 3; i++) begin
            code = 5'(dig[15:0] >> (11 - 5 * i));
            if (code > 9) bad = 1;
            val = val * 10 + code;
         end
      end else begin
         d0 = int'(dig[23:16]) - 48;
         d1 = int'(dig[15:8]) - 48;
         d2 = int'(dig[7:0]) - 48;
         val = d0 * 100 + d1 * 10 + d2;
      end
      if (bad) fp = h3se_pkg::FP_LINE;
      else begin
         pend = val[15:0];
         fp = h3se_pkg::FP_DONE_OK;
      end
   endtask

   task automatic section_byte(input logic [7:0] b, input logic [63:0] rem);
      logic [1:0]  which;
      logic [63:0] max;
      int          bits;
      which = fp[2:1];
      if (fp < h3se_pkg::FP_NAME_SKIP) begin
         if (!fp[0]) begin
            bits = 7;
            if (which == 2'd0) bits = 8;
            else if (which == 2'd2) begin
               if (b[7]) begin
                  bits = 6;
                  flags = {h3se_pkg::KindIdx, b[6]};
               end else if (b[7:6] == 2'b01) begin
                  bits = 4;
                  flags = {h3se_pkg::KindNref, b[4]};
               end else if (b[7:5] == 3'b001) begin
                  bits = 3;
                  flags = {h3se_pkg::KindLname, 1'b0};
               end else if (b[7:4] == 4'b0001) begin
                  bits = 4;
                  flags = {h3se_pkg::KindIdx, 1'b0};
               end else begin
                  bits = 3;
                  flags = {h3se_pkg::KindNref, 1'b0};
               end
            end else if (which == 2'd3) begin
               flags = {1'b0, b[7], flags[0]};
            end
            max = (64'd1 << bits) - 1;
            pacc = {56'd0, b} & max;
            shc = 0;
            if (pacc != max) finish_int(which, rem);
            else fp = h3se_pkg::field_phase_type'(fp | 4'd1);
         end else begin
            pacc = pacc + ({57'd0, b[6:0]} << (shc & 63));
            if (!b[7]) finish_int(which, rem);
            else begin
               shc = shc + 7;
               if (shc > 56) fp = h3se_pkg::FP_DONE_FAIL;
            end
         end
      end else if (fp == h3se_pkg::FP_NAME_SKIP) begin
         skl = skl - 1;
         if (skl == 0) fp = h3se_pkg::FP_VLEN;
      end else if (fp == h3se_pkg::FP_VAL_SKIP) begin
         skl = skl - 1;
         if (skl == 0) fp = h3se_pkg::FP_LINE;
      end else if (fp == h3se_pkg::FP_VAL_KEEP) begin
         dig = {dig[15:0], b};
         skl = skl - 1;
         if (skl == 0) finish_value();
      end
   endtask

   task automatic predict_status(input logic [7:0] b, input logic last,
                                 output bit got, output h3se_pkg::result_type r);
      bit done, ok;
      got = 0;
      ok = 0;
      r = '0;
      if (!answered) begin
         if (fr_ph < h3se_pkg::FR_SKIP) begin
            done = 0;
            if (!fr_ph[0]) begin
               vacc = {58'd0, b[5:0]};
               vleft = (1 << b[7:6]) - 1;
               if (vleft == 0) done = 1;
               else fr_ph = h3se_pkg::frame_phase_type'(fr_ph | 3'd1);
            end else begin
               vacc = (vacc << 8) | b;
               vleft--;
               if (vleft == 0) done = 1;
            end
            if (done) begin
               if (fr_ph[2:1] == 2'd0) begin
                  fr_ph = (vacc == 1) ? h3se_pkg::FR_HLEN : h3se_pkg::FR_LEN;
               end else if (fr_ph[2:1] == 2'd1) begin
                  if (vacc == 0) fr_ph = h3se_pkg::FR_TYPE;
                  else begin
                     fleft = vacc;
                     fr_ph = h3se_pkg::FR_SKIP;
                  end
               end else begin
                  clear_section();
                  if (vacc == 0) got = 1;
                  else begin
                     fleft = vacc;
                     fr_ph = h3se_pkg::FR_HBODY;
                  end
               end
            end
         end else if (fr_ph == h3se_pkg::FR_SKIP) begin
            fleft = fleft - 1;
            if (fleft == 0) fr_ph = h3se_pkg::FR_TYPE;
         end else begin
            fleft = fleft - 1;
            section_byte(b, fleft);
            if (fleft == 0) begin
               got = 1;
               ok = (fp == h3se_pkg::FP_DONE_OK);
            end
         end
         if (got) answered = 1;
      end
      if (last && !answered) got = 1;
      if (got) begin
         r.status_code = ok ? pend : 16'd0;
         r.failed = !ok;
      end
      if (last) clear_all();
   endtask

   task automatic add_byte(input logic [7:0] b, input logic last, input logic chk = 0,
                           input logic [15:0] st = 0, input logic fl = 0);
      byte_item_type it;
      it.data = b;
      it.last = last;
      it.chk = chk;
      it.st = st;
      it.fl = fl;
      stim_q.push_back(it);
   endtask

   task automatic put_int(input logic [7:0] pat, input int bits, input int v);
      int max;
      max = (1 << bits) - 1;
      if (v < max) bq.push_back(pat | v[7:0]);
      else begin
         bq.push_back(pat | max[7:0]);
         v = v - max;
         while (v >= 128) begin
            bq.push_back(8'h80 | v[6:0]);
            v = v >> 7;
         end
         bq.push_back(v[7:0]);
      end
   endtask

   task automatic put_value(input bit elig);
      int r, n;
      r = $urandom_range(0, 9);
      if (r < 4) begin
         bq.push_back(8'h03);
         for (int i = 0; i < 3; i++)
            bq.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'(8'h30 + $urandom_range(0, 9)));
      end else if (r < 8) begin
         logic [15:0] h;
         h = {$urandom_range(0, 9) == 0 ? 5'($urandom_range(10, 31))
                                        : 5'($urandom_range(0, 9)),
              5'($urandom_range(0, 9)), 5'($urandom_range(0, 11)), 1'($urandom_range(0, 1))};
         bq.push_back(8'h82);
         bq.push_back(h[15:8]);
         bq.push_back(h[7:0]);
      end else begin
         n = $urandom_range(0, 4);
         bq.push_back({$urandom_range(0, 1) == 1, 7'(n)});
         for (int i = 0; i < n; i++) bq.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic put_line();
      int r, idx, n;
      r = $urandom_range(0, 9);
      idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 99)
                                        : (($urandom_range(0, 1) == 1) ? $urandom_range(24, 28)
                                                                       : $urandom_range(63, 71));
      if (r < 3) put_int(8'hC0, 6, idx);
      else if (r < 4) put_int(8'h80, 6, $urandom_range(0, 80));
      else if (r < 7) begin
         put_int(8'(8'h50 | ($urandom_range(0, 1) << 5)), 4, idx);
         put_value(1);
      end else if (r < 8) begin
         put_int(8'h40, 4, $urandom_range(0, 30));
         put_value(0);
      end else if (r < 9) begin
         n = $urandom_range(0, 9);
         put_int(8'(8'h20 | ($urandom_range(0, 1) << 3)), 3, n);
         for (int i = 0; i < n; i++) bq.push_back(8'($urandom_range(0, 255)));
         put_value(0);
      end else begin
         if ($urandom_range(0, 1) == 1) put_int(8'h10, 4, $urandom_range(0, 20));
         else begin
            put_int(8'h00, 3, $urandom_range(0, 10));
            put_value(0);
         end
      end
   endtask

   task automatic make_buffer();
      logic [7:0] body[$];
      int len, n;
      bq.delete();
      if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(1, 8);
         for (int i = 0; i < n; i++) bq.push_back(8'($urandom_range(0, 255)));
      end else begin
         if ($urandom_range(0, 2) == 0) begin
            bq.push_back($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(2, 63)));
            n = $urandom_range(0, 5);
            bq.push_back(n[7:0]);
            for (int i = 0; i < n; i++) bq.push_back(8'($urandom_range(0, 255)));
         end
         if ($urandom_range(0, 3) == 0) begin
            bq.push_back(8'h40);
            bq.push_back(8'h01);
         end else bq.push_back(8'h01);
         body = bq;
         bq.delete();
         if ($urandom_range(0, 7) == 0) put_int(8'h00, 8, $urandom_range(255, 70000));
         else bq.push_back($urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255)) : 8'h00);
         bq.push_back($urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255)) : 8'h00);
         n = $urandom_range(1, 3);
         for (int i = 0; i < n; i++) put_line();
         len = bq.size();
         if ($urandom_range(0, 5) == 0) len = len + $urandom_range(0, 6) - 3;
         if (len < 0) len = 0;
         if (len >= 64 || $urandom_range(0, 4) == 0) begin
            body.push_back(8'h40 | len[13:8]);
            body.push_back(len[7:0]);
         end else body.push_back(len[7:0]);
         bq = {body, bq};
         n = $urandom_range(0, 2);
         for (int i = 0; i < n; i++) bq.push_back(8'($urandom_range(0, 255)));
      end
      foreach (bq[i]) add_byte(bq[i], i == bq.size() - 1);
   endtask

   function automatic void report(input h3se_pkg::result_type e,
                                  input h3se_pkg::result_type a);
      errors++;
      if (errors <= 10)
         $display("status item wrong: expected %0d/%0b, got %0d/%0b",
                  $signed(e.status_code), e.failed, $signed(a.status_code), a.failed);
   endfunction

   always @(posedge clock) begin
      bit got;
      h3se_pkg::result_type r, c;
      if (!reset && push && !full) begin
         predict_status(stim_q[0].data, stim_q[0].last, got, r);
         if (stim_q[0].chk) begin
            c.status_code = stim_q[0].st;
            c.failed = stim_q[0].fl;
            if (!got || r != c) report(c, r);
         end
         if (got) status_q.push_back(r);
         stim_q.pop_front();
         in_wait = gap();
      end
   end

   always @(posedge clock) begin
      h3se_pkg::result_type a, e;
      if (!reset && pop && !empty) begin
         a.status_code = rsp_status_code;
         a.failed = rsp_failed;
         if (status_q.size() == 0) report('0, a);
         else begin
            e = status_q.pop_front();
            if (e != a) report(e, a);
         end
         out_wait = gap();
      end
   end

   always @(negedge clock) begin
      if ($urandom_range(0, 299) == 0) calm = !calm;
      if (reset) begin
         push <= 1'b0;
         pop <= 1'b0;
      end else begin
         if (in_wait > 0) begin
            in_wait--;
            push <= 1'b0;
         end else if (stim_q.size() > 0) begin
            push <= 1'b1;
            req_data_byte <= stim_q[0].data;
            req_last_byte <= stim_q[0].last;
         end else push <= 1'b0;
         if (out_wait > 0) begin
            out_wait--;
            pop <= 1'b0;
         end else pop <= 1'b1;
      end
   end

   initial begin
      clear_all();
      add_byte(8'h01, 1'b0);
      add_byte(8'h00, 1'b1, 1'b1, 16'd0, 1'b1);
      add_byte(8'h01, 1'b0);
      add_byte(8'h03, 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'hD9, 1'b1, 1'b1, 16'd200, 1'b0);
      add_byte(8'h01, 1'b0);
      add_byte(8'h05, 1'b0);
      add_byte(8'h00, 1'b1, 1'b1, 16'd0, 1'b1);
      add_byte(8'h01, 1'b0);
      add_byte(8'h07, 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'h5F, 1'b0);
      add_byte(8'h0A, 1'b0);
      add_byte(8'h82, 1'b0);
      add_byte(8'h10, 1'b0);
      add_byte(8'h08, 1'b0);
      add_byte(8'hFF, 1'b1);
      add_byte(8'h07, 1'b0);
      add_byte(8'h01, 1'b0);
      add_byte(8'hAA, 1'b0);
      add_byte(8'h01, 1'b0);
      add_byte(8'hFF, 1'b1, 1'b1, 16'd0, 1'b1);
      while (stim_q.size() < 425) make_buffer();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      wait (stim_q.size() == 0 && status_q.size() == 0);
      repeat (20) @(posedge clock);
      if (errors == 0 && status_q.size() == 0)
         $display("http3_response_status_extractor_top: match");
      else
         $display("http3_response_status_extractor_top: mismatch");
      $finish;
   end

   initial begin
      #2000000;
      $display("http3_response_status_extractor_top: mismatch");
      $finish;
   end

endmodule
